// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SKT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/skt_pkg.sv -----
// Types and codes for the sorted key table
package skt_pkg;

    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = 5;

    localparam logic [1:0] ACT_FIND   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_DUP      = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SH_RD,
        ST_SH_WR,
        ST_PLACE,
        ST_RM_RD,
        ST_RM_WR,
        ST_RESULT
    } state_t;

endpackage

// ----- hdl/sorted_key_table.sv -----
// Sorted key table: find / insert / remove over a RAM of entries kept in key order.
// Search scans the RAM one entry a cycle up to the first entry whose key is at or above
// the key. Insert moves each entry above the slot up one place (a read state, then a write
// state) and then places the new entry; remove moves each entry above the hit down one place.
// One transaction at a time; the next is taken while a finished result waits in the output
// register. Reset clears the fill count and control state only; no clearing pass of the RAM.
module sorted_key_table import skt_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             action,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [HANDLE_BITS-1:0] handle,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic [HANDLE_BITS-1:0] found_handle,
    output logic [COUNT_BITS-1:0]  entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + HANDLE_BITS;

    state_t state_reg, state_next;

    logic [1:0]             act_reg, act_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic                   pend_reg, pend_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [HANDLE_BITS-1:0] res_fh_reg, res_fh_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg, status_next;
    logic [HANDLE_BITS-1:0] fh_reg, fh_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [KEY_BITS-1:0]    rd_key;
    logic [HANDLE_BITS-1:0] rd_hnd;
    logic [CW-1:0]          idx_inc, idx_dec, srch_pos;
    logic [CW:0]            pos_plus1, idx_plus2, fill_wide;
    logic [CW+COUNT_BITS-1:0] fill_ext;
    logic srch_issue, srch_ge, srch_end, srch_done, hit, full;
    logic is_insert, is_remove, rm_more, out_load;

    skt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[EW-1:HANDLE_BITS];
    assign rd_hnd = ram_rdata[HANDLE_BITS-1:0];

    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    // scan: read issued at idx, data for idx-1 compared in the next cycle
    assign srch_issue = (idx_reg < fill_reg);
    assign srch_ge    = pend_reg && (rd_key >= key_reg);
    assign srch_end   = !pend_reg && !srch_issue;
    assign srch_done  = srch_ge || srch_end;
    assign hit        = srch_ge && (rd_key == key_reg);
    assign srch_pos   = srch_ge ? idx_dec : idx_reg;

    assign fill_wide = {1'b0, fill_reg};
    assign pos_plus1 = {1'b0, srch_pos} + (CW+1)'(1);
    assign idx_plus2 = {1'b0, idx_reg} + (CW+1)'(2);
    assign rm_more   = (idx_plus2 < fill_wide);
    assign full      = (fill_reg >= CW'(CAPACITY));
    assign is_insert = (act_reg == ACT_INSERT);
    assign is_remove = (act_reg == ACT_REMOVE);
    assign out_load  = !out_valid_reg || !out_stall;
    assign fill_ext  = {{COUNT_BITS{1'b0}}, fill_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (srch_done)
                begin
                    if (is_insert)
                    begin
                        if (hit || full)
                        begin
                            state_next = ST_RESULT;
                        end
                        else if (srch_pos == fill_reg)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            state_next = ST_SH_RD;
                        end
                    end
                    else if (is_remove && hit && (pos_plus1 < fill_wide))
                    begin
                        state_next = ST_RM_RD;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SH_RD:
            begin
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                state_next = (idx_dec == pos_reg) ? ST_PLACE : ST_SH_RD;
            end
            ST_PLACE:
            begin
                state_next = ST_RESULT;
            end
            ST_RM_RD:
            begin
                state_next = ST_RM_WR;
            end
            ST_RM_WR:
            begin
                state_next = rm_more ? ST_RM_RD : ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        act_next        = act_reg;
        key_next        = key_reg;
        hnd_next        = hnd_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        pend_next       = 1'b0;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_fh_next     = res_fh_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        fh_next         = fh_reg;
        count_next      = count_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = action;
                    key_next = key;
                    hnd_next = handle;
                    idx_next = '0;
                end
            end
            ST_SEARCH:
            begin
                pend_next = srch_issue;
                if (srch_issue)
                begin
                    idx_next = idx_inc;
                end
                if (srch_done)
                begin
                    pos_next    = srch_pos;
                    res_fh_next = '0;
                    if (is_insert)
                    begin
                        idx_next = fill_reg;
                        if (hit)
                        begin
                            res_status_next = STAT_DUP;
                        end
                        else if (full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            res_status_next = STAT_OK;
                        end
                    end
                    else if (is_remove)
                    begin
                        idx_next = srch_pos;
                        if (hit)
                        begin
                            res_status_next = STAT_OK;
                            res_fh_next     = rd_hnd;
                            if (!(pos_plus1 < fill_wide))
                            begin
                                fill_next = fill_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            res_status_next = STAT_NOTFOUND;
                        end
                    end
                    else
                    begin
                        // find, and the spare action code
                        if (hit)
                        begin
                            res_status_next = STAT_OK;
                            res_fh_next     = rd_hnd;
                        end
                        else
                        begin
                            res_status_next = STAT_NOTFOUND;
                        end
                    end
                end
            end
            ST_SH_RD:
            begin
                ram_raddr = idx_dec[AW-1:0];
            end
            ST_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_dec;
            end
            ST_PLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = {key_reg, hnd_reg};
                fill_next = fill_reg + CW'(1);
            end
            ST_RM_RD:
            begin
                ram_raddr = idx_inc[AW-1:0];
            end
            ST_RM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (!rm_more)
                begin
                    fill_next = fill_reg - CW'(1);
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    fh_next        = res_fh_reg;
                    count_next     = fill_ext[COUNT_BITS-1:0];
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        hnd_reg        <= hnd_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_fh_reg     <= res_fh_next;
        status_reg     <= status_next;
        fh_reg         <= fh_next;
        count_reg      <= count_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_handle = fh_reg;
    assign entry_count  = count_reg;

endmodule

// ----- hdl/skt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/skt_checker.sv -----
// Port-level checks for the sorted key table, bound to the top level
`include "assert_macros.svh"

module skt_checker import skt_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [1:0]             status,
    input logic [HANDLE_BITS-1:0] found_handle,
    input logic [COUNT_BITS-1:0]  entry_count
);

    // a held result must not move
    `SKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(found_handle) && $stable(entry_count), "result changed while stalled")

    // handle only travels with a successful transaction
    `SKT_ASSERT_IMPL(a_fh_zero, out_valid && (status != STAT_OK), found_handle == '0, "handle set on failed transaction")

    // full is reported only when the table really is full
    `SKT_ASSERT_IMPL(a_full_count, out_valid && (status == STAT_FULL), entry_count == COUNT_BITS'(CAPACITY), "table full with free entries")

    // one transaction at a time: the input closes right after an accept
    `SKT_ASSERT_NEXT(a_one_busy, in_valid && !in_stall, in_stall, "second transaction taken while busy")

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (.*);

// ----- test/tb_sorted_key_table.sv -----
// Self-checking testbench for the sorted key table: directed corner cases, then random traffic
`timescale 1ns / 100ps

module tb_sorted_key_table import skt_pkg::*;;

    localparam int CAPACITY  = 16;
    localparam int KEY_BITS  = 31;
    localparam int KEY_POOL  = 24;
    localparam int N_RANDOM  = 525;
    localparam int LONG_HOLD = 300;
    localparam int TAIL      = 60;
    localparam int LIMIT     = 400000;

    // spare action code, decoded by the block as a find
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] handle;
        logic [COUNT_BITS-1:0]  count;
    } reply_t;

    // Shadow copy of the table; predicts one reply per request
    class key_table_shadow;
        logic [KEY_BITS-1:0]    shadow_keys[CAPACITY];
        logic [HANDLE_BITS-1:0] shadow_handles[CAPACITY];
        int                     shadow_fill;
        reply_t                 replies_due[$];
        int                     mismatches;

        function new();
            shadow_fill = 0;
            mismatches  = 0;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function void note_request(logic [1:0] act, logic [KEY_BITS-1:0] k,
                                   logic [HANDLE_BITS-1:0] h);
            int     pos;
            bit     hit;
            reply_t r;
            pos = 0;
            while (pos < shadow_fill && shadow_keys[pos] < k)
                pos++;
            hit      = (pos < shadow_fill) && (shadow_keys[pos] == k);
            r.status = STAT_OK;
            r.handle = '0;
            case (act)
                ACT_INSERT:
                begin
                    // duplicate wins over full
                    if (hit)
                        r.status = STAT_DUP;
                    else if (shadow_fill >= CAPACITY)
                        r.status = STAT_FULL;
                    else
                    begin
                        for (int i = shadow_fill; i > pos; i--)
                        begin
                            shadow_keys[i]    = shadow_keys[i-1];
                            shadow_handles[i] = shadow_handles[i-1];
                        end
                        shadow_keys[pos]    = k;
                        shadow_handles[pos] = h;
                        shadow_fill++;
                    end
                end
                ACT_REMOVE:
                begin
                    if (!hit)
                        r.status = STAT_NOTFOUND;
                    else
                    begin
                        r.handle = shadow_handles[pos];
                        for (int i = pos; i + 1 < shadow_fill; i++)
                        begin
                            shadow_keys[i]    = shadow_keys[i+1];
                            shadow_handles[i] = shadow_handles[i+1];
                        end
                        shadow_fill--;
                    end
                end
                default:
                begin
                    if (hit)
                        r.handle = shadow_handles[pos];
                    else
                        r.status = STAT_NOTFOUND;
                end
            endcase
            r.count = COUNT_BITS'(shadow_fill);
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [HANDLE_BITS-1:0] fh,
                                  logic [COUNT_BITS-1:0] cnt);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("reply with no request outstanding: status %0d handle %0h count %0d",
                       st, fh, cnt);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatches++;
            end
            if (fh !== want.handle)
            begin
                $error("found_handle: expected %0h, got %0h", want.handle, fh);
                mismatches++;
            end
            if (cnt !== want.count)
            begin
                $error("entry_count: expected %0d, got %0d", want.count, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             action;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] found_handle;
    logic [COUNT_BITS-1:0]  entry_count;

    key_table_shadow     tracker = new();
    logic [KEY_BITS-1:0] key_pool[KEY_POOL];
    bit                  quiet        = 1'b0;
    bit                  hold_replies = 1'b0;
    int                  cycles       = 0;

    sorted_key_table #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .key          (key),
        .handle       (handle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_handle (found_handle),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reply(status, found_handle, entry_count);
    end

    // Reply side: short stall bursts, calm stretches, and one long hold on request
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_replies)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_replies = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 60)) @(negedge clk);
        end
    end

    // Valid stays high between back-to-back transactions; lowered only for a random gap or while waiting for replies
    task automatic issue_request(input logic [1:0] act, input logic [KEY_BITS-1:0] k,
                                 input logic [HANDLE_BITS-1:0] h);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        action   <= act;
        key      <= k;
        handle   <= h;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(act, k, h);
    endtask

    task automatic wait_for_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return KEY_BITS'($urandom);
    endfunction

    initial
    begin
        int         n;
        int         roll;
        bit         growing;
        logic [1:0] act;
        growing  = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= ACT_FIND;
        key      <= '0;
        handle   <= '0;
        for (n = 0; n < KEY_POOL; n++)
            key_pool[n] = KEY_BITS'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // empty table, extremes, duplicate, spare code
        issue_request(ACT_FIND, 31'd5, 16'($urandom));
        issue_request(ACT_REMOVE, 31'd5, 16'($urandom));
        issue_request(ACT_INSERT, '0, 16'h0000);
        issue_request(ACT_INSERT, '1, 16'hFFFF);
        issue_request(ACT_INSERT, '0, 16'h1234);
        issue_request(ACT_SPARE, '1, 16'($urandom));
        issue_request(ACT_FIND, '0, 16'($urandom));
        // descending order so each insert shifts everything above it
        for (n = 14; n >= 1; n--)
            issue_request(ACT_INSERT, KEY_BITS'(n * 32'h0924_9249), 16'($urandom));
        issue_request(ACT_INSERT, 31'd1, 16'($urandom));
        issue_request(ACT_INSERT, '1, 16'($urandom));
        issue_request(ACT_REMOVE, '1, 16'($urandom));
        issue_request(ACT_REMOVE, '0, 16'($urandom));
        issue_request(ACT_REMOVE, 31'd2, 16'($urandom));
        issue_request(ACT_FIND, KEY_BITS'(7 * 32'h0924_9249), 16'($urandom));
        wait_for_replies();

        // alternate growing and shrinking phases so the table swings between empty and full
        for (n = 0; n < N_RANDOM; n++)
        begin
            if (n % 55 == 0)
                growing = !growing;
            if (n == N_RANDOM - 60)
                quiet = 1'b1;
            if (n == 150)
                hold_replies = 1'b1;
            if (n == 300)
                wait_for_replies();
            roll = $urandom_range(0, 99);
            if (roll < (growing ? 55 : 15))
                act = ACT_INSERT;
            else if (roll < (growing ? 70 : 60))
                act = ACT_REMOVE;
            else if (roll < 95)
                act = ACT_FIND;
            else
                act = ACT_SPARE;
            issue_request(act, pick_key(), 16'($urandom));
        end

        wait_for_replies();
        repeat (TAIL) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sorted_key_table.f -----
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/sorted_key_table.sv
hdl/skt_checker.sv
test/tb_sorted_key_table.sv
